>>> src/md5_stream_hasher_assert.svh
// Assertion macros for the hasher RTL.
// Each check is clocked on clk_i and held off while rst_ni is low.
`ifndef MD5_STREAM_HASHER_ASSERT_SVH
`define MD5_STREAM_HASHER_ASSERT_SVH

// Check that a property holds at every clock edge.
`define MD5SH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge.
`define MD5SH_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/md5sh_pkg.sv
// ---------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and round helper functions for the streaming MD5 hasher.
// ---------------------------------------------------------------------------
`default_nettype none

package md5sh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [3:0]       addr_t;
  typedef logic [5:0]       round_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_RUN,
    ST_FOLD,
    ST_EMIT
  } state_e;

  // Chaining value after reset
  localparam word_t IvA = 32'h67452301;
  localparam word_t IvB = 32'hefcdab89;
  localparam word_t IvC = 32'h98badcfe;
  localparam word_t IvD = 32'h10325476;

  localparam logic [7:0] PadLead      = 8'h80;
  localparam logic [5:0] FillLast     = 6'd63;
  localparam logic [5:0] FillLenStart = 6'd56;
  localparam logic [2:0] LenLast      = 3'd7;
  localparam round_t     RoundLast    = 6'd63;

  // Additive round constants
  localparam word_t RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts by phase and round within a group of four
  localparam logic [4:0] RotAmt [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic   load;   // copy chaining words into the working words
    logic   step;   // run one round
    logic   fold;   // add working words into the chaining words
    logic   init;   // restore the initial chaining value
    round_t round;
  } core_ctl_t;

  // Block memory request
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // Message word used by a given round
  function automatic addr_t msg_idx(round_t rnd);
    addr_t r;
    addr_t idx;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = r;
      2'd1:    idx = addr_t'(r * 4'd5 + 4'd1);
      2'd2:    idx = addr_t'(r * 4'd3 + 4'd5);
      default: idx = addr_t'(r * 4'd7);
    endcase
    return idx;
  endfunction

  // Nonlinear round function
  function automatic word_t md5_f(logic [1:0] phase, word_t b, word_t c, word_t d);
    word_t f;
    case (phase)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

>>> src/md5sh_if.sv
// ---------------------------------------------------------------------------
// md5sh_if
// Valid/ready channels of the hasher: byte input and digest output.
// ---------------------------------------------------------------------------
`default_nettype none

interface md5sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  modport source (output valid, output digest_low, output digest_high, input ready);
  modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

`default_nettype wire

>>> src/md5sh_ram.sv
// ---------------------------------------------------------------------------
// md5sh_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module md5sh_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/md5sh_core.sv
// ---------------------------------------------------------------------------
// md5sh_core
// Round datapath: chaining words, working words and one MD5 round per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module md5sh_core import md5sh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire core_ctl_t  ctl_i,
  input  wire word_t      msg_i,
  output logic    [127:0] digest_o
);

  word_t chain_q [4];
  word_t a_q, b_q, c_q, d_q;
  word_t f_w, t_w, rot_w, nb_w;
  logic [63:0] dbl_w;
  logic [4:0]  amt_w;

  // Round function, sum and rotate
  always_comb begin
    f_w   = md5_f(ctl_i.round[5:4], b_q, c_q, d_q);
    t_w   = a_q + f_w + msg_i + RoundK[ctl_i.round];
    amt_w = RotAmt[ctl_i.round[5:4]][ctl_i.round[1:0]];
    dbl_w = {t_w, t_w} << amt_w;
    rot_w = dbl_w[63:32];
    nb_w  = b_q + rot_w;
  end

  // Working words
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (ctl_i.step) begin
      a_q <= d_q;
      b_q <= nb_w;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

  // Chaining words: fold after each block, restore after each digest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= IvA;
      chain_q[1] <= IvB;
      chain_q[2] <= IvC;
      chain_q[3] <= IvD;
    end else if (ctl_i.init) begin
      chain_q[0] <= IvA;
      chain_q[1] <= IvB;
      chain_q[2] <= IvC;
      chain_q[3] <= IvD;
    end else if (ctl_i.fold) begin
      chain_q[0] <= chain_q[0] + a_q;
      chain_q[1] <= chain_q[1] + b_q;
      chain_q[2] <= chain_q[2] + c_q;
      chain_q[3] <= chain_q[3] + d_q;
    end
  end

  assign digest_o = {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};

endmodule

`default_nettype wire

>>> src/md5sh_ctrl.sv
// ---------------------------------------------------------------------------
// md5sh_ctrl
// Sequencer: byte gathering, length count, padding and compression control.
// ---------------------------------------------------------------------------
`default_nettype none

`include "md5_stream_hasher_assert.svh"

module md5sh_ctrl import md5sh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_present_i,
  input  wire logic       end_of_message_i,
  input  wire logic       out_full_i,
  output logic            emit_o,
  output core_ctl_t       ctl_o,
  output mem_req_t        mem_o
);

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] count_q, count_d;
  logic [23:0] word_q, word_d;
  logic        closing_q, closing_d;
  logic        lead_q, lead_d;
  logic        len_q, len_d;
  logic [2:0]  len_idx_q, len_idx_d;
  logic        done_q, done_d;
  round_t      round_q, round_d;

  logic        in_fire;
  logic        absorb;
  logic [7:0]  abs_byte;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  round_t      round_nx;

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign bit_len  = count_q << 3;
  assign len_byte = bit_len[{len_idx_q, 3'b000} +: 8];
  assign round_nx = round_q + 6'd1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (byte_present_i && fill_q == FillLast) begin
            state_d = ST_LOAD;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == FillLast) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_RUN;
      ST_RUN: begin
        if (round_q == RoundLast) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!closing_q) begin
          state_d = ST_IDLE;
        end else if (done_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (!out_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and register updates
  always_comb begin
    fill_d     = fill_q;
    count_d    = count_q;
    word_d     = word_q;
    closing_d  = closing_q;
    lead_d     = lead_q;
    len_d      = len_q;
    len_idx_d  = len_idx_q;
    done_d     = done_q;
    round_d    = round_q;
    absorb     = 1'b0;
    abs_byte   = '0;
    mem_o      = '0;
    ctl_o      = '0;
    emit_o     = 1'b0;
    in_ready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (byte_present_i) begin
            absorb   = 1'b1;
            abs_byte = data_byte_i;
            count_d  = count_q + 64'd1;
          end
          if (end_of_message_i) begin
            closing_d = 1'b1;
            lead_d    = 1'b1;
          end
        end
      end
      ST_PAD: begin
        // 0x80 marker, zeros up to 56, then the bit length
        absorb = 1'b1;
        if (lead_q) begin
          abs_byte = PadLead;
          lead_d   = 1'b0;
        end else if (len_q || fill_q == FillLenStart) begin
          abs_byte  = len_byte;
          len_d     = 1'b1;
          len_idx_d = len_idx_q + 3'd1;
          if (len_idx_q == LenLast) begin
            done_d = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        ctl_o.load = 1'b1;
        mem_o.re   = 1'b1;
        mem_o.raddr = msg_idx('0);
        round_d    = '0;
      end
      ST_RUN: begin
        ctl_o.step  = 1'b1;
        ctl_o.round = round_q;
        mem_o.re    = 1'b1;
        mem_o.raddr = msg_idx(round_nx);
        round_d     = round_nx;
      end
      ST_FOLD: begin
        ctl_o.fold = 1'b1;
      end
      ST_EMIT: begin
        if (!out_full_i) begin
          emit_o     = 1'b1;
          ctl_o.init = 1'b1;
          count_d    = '0;
          closing_d  = 1'b0;
          len_d      = 1'b0;
          len_idx_d  = '0;
          done_d     = 1'b0;
        end
      end
      default: ;
    endcase

    // Gather bytes little-endian; write each completed word
    if (absorb) begin
      fill_d = fill_q + 6'd1;
      case (fill_q[1:0])
        2'd0:    word_d[7:0]   = abs_byte;
        2'd1:    word_d[15:8]  = abs_byte;
        2'd2:    word_d[23:16] = abs_byte;
        default: begin
          mem_o.we    = 1'b1;
          mem_o.waddr = fill_q[5:2];
          mem_o.wdata = {abs_byte, word_q};
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      count_q   <= '0;
      closing_q <= 1'b0;
      lead_q    <= 1'b0;
      len_q     <= 1'b0;
      len_idx_q <= '0;
      done_q    <= 1'b0;
      round_q   <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
      closing_q <= closing_d;
      lead_q    <= lead_d;
      len_q     <= len_d;
      len_idx_q <= len_idx_d;
      done_q    <= done_d;
      round_q   <= round_d;
    end
  end

  // Partial word under assembly
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  `MD5SH_NEVER(a_no_rw_overlap, mem_o.we && mem_o.re, "block write during compression read")
  `MD5SH_ASSERT(a_load_full, (state_q == ST_LOAD) |-> (fill_q == 6'd0), "compression on partial block")
  `MD5SH_ASSERT(a_run_to_fold, (state_q == ST_RUN && round_q == RoundLast) |=> (state_q == ST_FOLD), "round count overrun")
  `MD5SH_ASSERT(a_pad_count, (state_q == ST_PAD) |=> $stable(count_q), "byte count moved during padding")
  `MD5SH_ASSERT(a_emit_done, emit_o |-> (done_q && fill_q == 6'd0), "digest before length absorbed")

endmodule

`default_nettype wire

>>> src/md5_stream_hasher.sv
// ---------------------------------------------------------------------------
// md5_stream_hasher
// Streaming MD5: one optional message byte per item, digest on end of message.
// ---------------------------------------------------------------------------
//  Channel  Dir  Payload                                     Transfer
//  in_i     in   data_byte, byte_present, end_of_message     valid & ready
//  out_o    out  digest_low (A,B), digest_high (C,D)         valid & ready
//
//  A byte item that does not complete a block or end the message leaves input ready.
//  The 64th byte of a block starts compression: a load step, 64 rounds
//  (one round per cycle, message word read from block RAM the cycle before)
//  and a fold step, so input is held off from that item until the fold.
//  End of message pads one byte per cycle, runs one or two compressions and
//  then loads the output register; while an earlier digest is still untaken
//  the new digest waits in the core, input held off until the output is free.
//  The block RAM has no reset; every word is written before it is read.
// ---------------------------------------------------------------------------
`default_nettype none

module md5_stream_hasher import md5sh_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  md5sh_in_if.sink    in_i,
  md5sh_out_if.source out_o
);

  core_ctl_t    ctl;
  mem_req_t     mem_req;
  word_t        msg_word;
  logic [127:0] digest;
  logic         emit;
  logic         out_full;
  logic         out_valid_q;
  logic [63:0]  out_low_q;
  logic [63:0]  out_high_q;

  assign out_full = out_valid_q && !out_o.ready;

  md5sh_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .data_byte_i      (in_i.data_byte),
    .byte_present_i   (in_i.byte_present),
    .end_of_message_i (in_i.end_of_message),
    .out_full_i       (out_full),
    .emit_o           (emit),
    .ctl_o            (ctl),
    .mem_o            (mem_req)
  );

  md5sh_ram #(
    .Depth (BlkWords),
    .Width (WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (msg_word)
  );

  md5sh_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .msg_i    (msg_word),
    .digest_o (digest)
  );

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_low_q  <= digest[63:0];
      out_high_q <= digest[127:64];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_low  = out_low_q;
  assign out_o.digest_high = out_high_q;

endmodule

`default_nettype wire
